[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define MTEE_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion, also checked while reset is high
`define MTEE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[sv/mtee_pkg.sv]
// ----------------------------------------------------------------------------
// mtee_pkg
// types and constants of the midi track event encoder
// ----------------------------------------------------------------------------
package mtee_pkg;

  localparam int DELTA_W = 28;
  localparam int NIB_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 32;
  localparam int GROUP_W = 7;
  localparam int SEQ_MAX = 7;
  localparam int POS_W   = 3;

  localparam logic ACT_EVENT  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] META_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] EOT_BYTE  = 8'h2F;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  localparam logic [POS_W-1:0] EOT_LEN = 3'd4;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                     finish;
    logic [POS_W-1:0]         count;
    byte_t [SEQ_MAX-1:0]      seq;
  } cmd_t;

endpackage

[sv/mtee_ifs.sv]
// ----------------------------------------------------------------------------
// mtee_ifs
// valid/ready channels of the encoder: event items in, track bytes out
// ----------------------------------------------------------------------------
interface mtee_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [mtee_pkg::DELTA_W-1:0]  delta_time;
  logic [mtee_pkg::NIB_W-1:0]    event_type;
  logic [mtee_pkg::NIB_W-1:0]    channel;
  logic [mtee_pkg::BYTE_W-1:0]   first_param;
  logic [mtee_pkg::BYTE_W-1:0]   second_param;

  modport source (output valid, action, delta_time, event_type, channel,
                  first_param, second_param, input ready);
  modport sink   (input valid, action, delta_time, event_type, channel,
                  first_param, second_param, output ready);
endinterface

interface mtee_out_if;
  logic                         valid;
  logic                         ready;
  logic [mtee_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;
  logic [mtee_pkg::LEN_W-1:0]   track_length;

  modport source (output valid, data_byte, last_byte, track_length, input ready);
  modport sink   (input valid, data_byte, last_byte, track_length, output ready);
endinterface

[sv/mtee_front.sv]
// ----------------------------------------------------------------------------
// mtee_front
// accepts event items and builds the byte sequence of each one
// ----------------------------------------------------------------------------
module mtee_front (
  mtee_in_if.sink          src,
  input  logic             full,
  output logic             push,
  output mtee_pkg::cmd_t   cmd
);
  import mtee_pkg::*;

  logic [GROUP_W-1:0] g3, g2, g1, g0;
  byte_t              status;

  assign src.ready = !full;
  assign push      = src.valid && !full;

  assign g3     = src.delta_time[27:21];
  assign g2     = src.delta_time[20:14];
  assign g1     = src.delta_time[13:7];
  assign g0     = src.delta_time[6:0];
  assign status = {src.event_type, src.channel};

  always_comb begin
    cmd        = '0;
    cmd.finish = (src.action == ACT_FINISH);
    if (src.action == ACT_FINISH) begin
      cmd.seq[0] = ZERO_BYTE;
      cmd.seq[1] = META_BYTE;
      cmd.seq[2] = EOT_BYTE;
      cmd.seq[3] = ZERO_BYTE;
      cmd.count  = EOT_LEN;
    end else begin
      priority if (g3 != '0) begin
        cmd.seq[0] = CONT_BIT | {1'b0, g3};
        cmd.seq[1] = CONT_BIT | {1'b0, g2};
        cmd.seq[2] = CONT_BIT | {1'b0, g1};
        cmd.seq[3] = {1'b0, g0};
        cmd.seq[4] = status;
        cmd.seq[5] = src.first_param;
        cmd.seq[6] = src.second_param;
        cmd.count  = 3'd7;
      end else if (g2 != '0) begin
        cmd.seq[0] = CONT_BIT | {1'b0, g2};
        cmd.seq[1] = CONT_BIT | {1'b0, g1};
        cmd.seq[2] = {1'b0, g0};
        cmd.seq[3] = status;
        cmd.seq[4] = src.first_param;
        cmd.seq[5] = src.second_param;
        cmd.count  = 3'd6;
      end else if (g1 != '0) begin
        cmd.seq[0] = CONT_BIT | {1'b0, g1};
        cmd.seq[1] = {1'b0, g0};
        cmd.seq[2] = status;
        cmd.seq[3] = src.first_param;
        cmd.seq[4] = src.second_param;
        cmd.count  = 3'd5;
      end else begin
        cmd.seq[0] = {1'b0, g0};
        cmd.seq[1] = status;
        cmd.seq[2] = src.first_param;
        cmd.seq[3] = src.second_param;
        cmd.count  = 3'd4;
      end
    end
  end

endmodule

[sv/mtee_queue.sv]
// ----------------------------------------------------------------------------
// mtee_queue
// two-entry queue of byte sequences between front and back
// ----------------------------------------------------------------------------
module mtee_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtee_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output mtee_pkg::cmd_t   head,
  output logic             full,
  output logic             empty
);
  import mtee_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[sv/mtee_back.sv]
// ----------------------------------------------------------------------------
// mtee_back
// sends one byte per cycle while the output is not stalled, keeps the track byte count
// ----------------------------------------------------------------------------
module mtee_back (
  input  logic             clk,
  input  logic             rst,
  input  mtee_pkg::cmd_t   head,
  input  logic             empty,
  output logic             pop,
  mtee_out_if.source       dst
);
  import mtee_pkg::*;

  logic              busy;
  cmd_t              cur;
  logic [POS_W-1:0]  pos;
  logic [LEN_W-1:0]  byte_count;
  logic              out_valid;
  byte_t             out_data;
  logic              out_last;
  logic [LEN_W-1:0]  out_len;
  logic              emit;
  logic              is_last;

  assign emit    = busy && (!out_valid || dst.ready);
  assign is_last = (pos == cur.count - 3'd1);
  assign pop     = !empty && (!busy || (emit && is_last));

  assign dst.valid        = out_valid;
  assign dst.data_byte    = out_data;
  assign dst.last_byte    = out_last;
  assign dst.track_length = out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pos        <= '0;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (dst.ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= cur.seq[pos];
        out_last  <= is_last;
        out_len   <= (cur.finish && is_last) ? byte_count + LEN_W'(EOT_LEN) : '0;
        pos       <= pos + 3'd1;
        if (is_last) begin
          byte_count <= cur.finish ? '0 : byte_count + LEN_W'(cur.count);
        end
      end
      if (pop) begin
        cur  <= head;
        pos  <= '0;
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/midi_track_event_encoder_top.sv]
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top
// turns track events into midi track bytes with vlq delta times
// ----------------------------------------------------------------------------
//  channel      dir  payload
//  track_event  in   action, delta_time, event_type, channel, first/second_param
//  track_byte   out  data_byte, last_byte, track_length
//
//  an event is 4 to 7 bytes (vlq length + 3), a finish 4 bytes, one byte
//  per cycle from the back-end serializer while the output is not stalled
//  synchronous reset clears the queue, the serializer and the byte count
//  a two-entry queue lets events be taken while bytes are stalled
//  the output register holds a beat until it is taken
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top (
  input  logic         clk,
  input  logic         rst,
  mtee_in_if.sink      track_event,
  mtee_out_if.source   track_byte
);
  import mtee_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  mtee_front u_front (
    .src  (track_event),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  mtee_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  mtee_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .dst   (track_byte)
  );

endmodule

[sv/mtee_checker.sv]
// ----------------------------------------------------------------------------
// mtee_checker
// port-level checks of the encoder output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtee_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mtee_pkg::BYTE_W-1:0] data_byte,
  input logic                        last_byte,
  input logic [mtee_pkg::LEN_W-1:0]  track_length
);
  import mtee_pkg::*;

  `MTEE_ASSERT_CLK(a_valid_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `MTEE_ASSERT_CLK(a_beat_stable, clk, rst, out_valid && !out_ready |=> $stable(data_byte) && $stable(last_byte) && $stable(track_length))
  `MTEE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)
  `MTEE_ASSERT_CLK(a_length_on_eot, clk, rst, out_valid && track_length != '0 |-> last_byte && data_byte == ZERO_BYTE)

endmodule

bind midi_track_event_encoder_top mtee_checker u_mtee_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (track_byte.valid),
  .out_ready    (track_byte.ready),
  .data_byte    (track_byte.data_byte),
  .last_byte    (track_byte.last_byte),
  .track_length (track_byte.track_length)
);

[tb/midi_track_event_encoder_top_tb.sv]
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top_tb
// checks the track byte stream of the midi track event encoder: a table of
// directed events and finishes, then random tracks, with random gaps on the
// event side and random stalls on the byte side; every byte is compared with
// the table's bytes or with a local vlq encoder and byte counter
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top_tb;
  import mtee_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int RAND_ITEMS = 200;

  typedef struct packed {
    logic               action;
    logic [DELTA_W-1:0] delta;
    logic [NIB_W-1:0]   etype;
    logic [NIB_W-1:0]   chan;
    byte_t              p1;
    byte_t              p2;
  } track_item_t;

  typedef struct packed {
    byte_t            data;
    logic             last;
    logic [LEN_W-1:0] len;
  } track_beat_t;

  typedef struct packed {
    track_item_t      item;
    logic [2:0]       nbytes;
    logic [55:0]      bytes;
    logic [LEN_W-1:0] len;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtee_in_if  ev_if ();
  mtee_out_if by_if ();

  midi_track_event_encoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .track_event (ev_if),
    .track_byte  (by_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  track_beat_t      track_bytes_due[$];
  track_beat_t      encoded_bytes[$];
  table_row_t       event_table[$];
  logic [LEN_W-1:0] track_count;
  logic             calm;
  int               mismatch_count;
  int               event_count;
  int               finish_count;
  int               beat_count;

  // vlq delta, status, params, or the end-of-track meta event
  function automatic void encode_track_item(input track_item_t it);
    int          ngroups;
    logic [31:0] delta;
    track_beat_t b;
    encoded_bytes.delete();
    if (it.action == ACT_FINISH) begin
      b = '{ZERO_BYTE, 1'b0, '0};
      encoded_bytes = {encoded_bytes, b};
      b.data = META_BYTE;
      encoded_bytes = {encoded_bytes, b};
      b.data = EOT_BYTE;
      encoded_bytes = {encoded_bytes, b};
      b = '{ZERO_BYTE, 1'b1, track_count + 32'd4};
      encoded_bytes = {encoded_bytes, b};
      track_count = '0;
    end else begin
      delta = 32'(it.delta);
      ngroups = 1;
      while (ngroups < 4 && (delta >> (GROUP_W * ngroups)) != 0) ngroups++;
      for (int i = ngroups - 1; i >= 0; i--) begin
        b.data = {1'b0, delta[GROUP_W*i +: GROUP_W]} | ((i > 0) ? CONT_BIT : ZERO_BYTE);
        b.last = 1'b0;
        b.len  = '0;
        encoded_bytes = {encoded_bytes, b};
      end
      b = '{{it.etype, it.chan}, 1'b0, '0};
      encoded_bytes = {encoded_bytes, b};
      b.data = it.p1;
      encoded_bytes = {encoded_bytes, b};
      b = '{it.p2, 1'b1, '0};
      encoded_bytes = {encoded_bytes, b};
      track_count = track_count + 32'(encoded_bytes.size());
    end
  endfunction

  task automatic send_item(input table_row_t row);
    int          gap;
    track_beat_t b;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      ev_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev_if.action       = row.item.action;
    ev_if.delta_time   = row.item.delta;
    ev_if.event_type   = row.item.etype;
    ev_if.channel      = row.item.chan;
    ev_if.first_param  = row.item.p1;
    ev_if.second_param = row.item.p2;
    ev_if.valid        = 1'b1;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    encode_track_item(row.item);
    if (row.nbytes != 0) begin
      for (int k = 0; k < row.nbytes; k++) begin
        b.data = row.bytes[55 - 8*k -: 8];
        b.last = (k == row.nbytes - 1);
        b.len  = b.last ? row.len : '0;
        track_bytes_due = {track_bytes_due, b};
      end
    end else begin
      track_bytes_due = {track_bytes_due, encoded_bytes};
    end
    if (row.item.action == ACT_FINISH) finish_count++;
    else event_count++;
    @(negedge clk);
    ev_if.valid = 1'b0;
  endtask

  task automatic drain_track_bytes();
    while (track_bytes_due.size() != 0) @(negedge clk);
  endtask

  function automatic table_row_t mk_row(input logic act, input logic [DELTA_W-1:0] delta,
                                        input logic [NIB_W-1:0] etype,
                                        input logic [NIB_W-1:0] chan,
                                        input byte_t p1, input byte_t p2,
                                        input logic [2:0] nbytes, input logic [55:0] bytes,
                                        input logic [LEN_W-1:0] len);
    table_row_t r;
    r.item   = '{act, delta, etype, chan, p1, p2};
    r.nbytes = nbytes;
    r.bytes  = bytes;
    r.len    = len;
    return r;
  endfunction

  function automatic void add_row(input table_row_t r);
    event_table = {event_table, r};
  endfunction

  function automatic table_row_t random_row();
    table_row_t r;
    int         vlq_len;
    int         lo;
    int         hi;
    r = '0;
    r.item.action = ($urandom_range(0, 99) < 15) ? ACT_FINISH : ACT_EVENT;
    vlq_len = $urandom_range(1, 4);
    lo = (vlq_len == 1) ? 0 : (1 << (GROUP_W * (vlq_len - 1)));
    hi = (1 << (GROUP_W * vlq_len)) - 1;
    case ($urandom_range(0, 7))
      0:       r.item.delta = DELTA_W'(lo);
      1:       r.item.delta = DELTA_W'(hi);
      default: r.item.delta = DELTA_W'($urandom_range(hi, lo));
    endcase
    r.item.etype = NIB_W'($urandom_range(0, 15));
    r.item.chan  = NIB_W'($urandom_range(0, 15));
    r.item.p1    = byte_t'($urandom_range(0, 255));
    r.item.p2    = byte_t'($urandom_range(0, 255));
    return r;
  endfunction

  // byte side: random stall per beat, compare on every accepted beat
  initial begin
    int          stall;
    track_beat_t want;
    by_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        by_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      by_if.ready = 1'b1;
      @(posedge clk);
      while (!by_if.valid) @(posedge clk);
      beat_count++;
      if (track_bytes_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat data_byte=%02h last_byte=%0b track_length=%0d",
                 $time, by_if.data_byte, by_if.last_byte, by_if.track_length);
      end else begin
        want = track_bytes_due.pop_front();
        if (by_if.data_byte !== want.data) begin
          mismatch_count++;
          $display("%0t: data_byte expected %02h actual %02h",
                   $time, want.data, by_if.data_byte);
        end
        if (by_if.last_byte !== want.last) begin
          mismatch_count++;
          $display("%0t: last_byte expected %0b actual %0b",
                   $time, want.last, by_if.last_byte);
        end
        if (by_if.track_length !== want.len) begin
          mismatch_count++;
          $display("%0t: track_length expected %0d actual %0d",
                   $time, want.len, by_if.track_length);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    table_row_t row;
    mismatch_count = 0;
    event_count    = 0;
    finish_count   = 0;
    beat_count     = 0;
    track_count    = '0;
    calm           = 1'b0;
    ev_if.valid        = 1'b0;
    ev_if.action       = ACT_EVENT;
    ev_if.delta_time   = '0;
    ev_if.event_type   = '0;
    ev_if.channel      = '0;
    ev_if.first_param  = '0;
    ev_if.second_param = '0;

    // finish on an empty track, then vlq length edges, then the longest delta
    add_row(mk_row(ACT_FINISH, '1, 4'hF, 4'hF, 8'hFF, 8'hFF,
                   3'd4, 56'h00FF2F00_000000, 32'd4));
    add_row(mk_row(ACT_EVENT, 28'h0, 4'h0, 4'h0, 8'h00, 8'h00,
                   3'd4, 56'h00000000_000000, '0));
    add_row(mk_row(ACT_EVENT, 28'h7F, 4'hF, 4'hF, 8'hFF, 8'hFF,
                   3'd4, 56'h7FFFFFFF_000000, '0));
    add_row(mk_row(ACT_EVENT, 28'h80, 4'h9, 4'h0, 8'h3C, 8'h40,
                   3'd5, 56'h8100903C_400000, '0));
    add_row(mk_row(ACT_EVENT, 28'h3FFF, 4'h8, 4'h1, 8'h3C, 8'h00,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h4000, 4'hA, 4'h2, 8'h55, 8'hAA,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h1FFFFF, 4'hB, 4'h7, 8'h07, 8'h7F,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h200000, 4'hC, 4'h8, 8'h80, 8'h01,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'hFFFFFFF, 4'h8, 4'h0, 8'h12, 8'h34,
                   3'd7, 56'hFFFFFF7F_801234, '0));
    add_row(mk_row(ACT_FINISH, 28'h5A5A5A5, 4'h5, 4'hA, 8'hA5, 8'h5A,
                   3'd4, 56'h00FF2F00_000000, 32'd48));
    add_row(mk_row(ACT_FINISH, 28'h0, 4'h0, 4'h0, 8'h00, 8'h00,
                   3'd4, 56'h00FF2F00_000000, 32'd4));
    add_row(mk_row(ACT_EVENT, 28'h1, 4'hD, 4'h3, 8'h40, 8'h00,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'hAAAAAAA, 4'hE, 4'h5, 8'h00, 8'h40,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h5555555, 4'h1, 4'hC, 8'hC3, 8'h3C,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h81, 4'h2, 4'h6, 8'hF0, 8'h0F,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h0FFFFF, 4'h3, 4'h9, 8'h01, 8'h80,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h2345, 4'h4, 4'hB, 8'hFE, 8'hEF,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h7, 4'h6, 4'hD, 8'h11, 8'h22,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_EVENT, 28'h8000000, 4'h7, 4'hE, 8'h33, 8'h44,
                   3'd0, '0, '0));
    add_row(mk_row(ACT_FINISH, 28'h0, 4'h0, 4'h0, 8'h00, 8'h00,
                   3'd0, '0, '0));

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (event_table[i]) send_item(event_table[i]);
    drain_track_bytes();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 60 && i < 90) || (i >= 140 && i < 165);
      if (i % 50 == 49) drain_track_bytes();
      row = random_row();
      send_item(row);
    end
    row = '0;
    row.item.action = ACT_FINISH;
    send_item(row);
    ev_if.valid = 1'b0;
    calm = 1'b0;

    drain_track_bytes();
    repeat (40) @(posedge clk);

    $display("covered %0d events and %0d finishes, %0d track bytes checked",
             event_count, finish_count, beat_count);
    if (mismatch_count == 0) begin
      $display("midi_track_event_encoder_top_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("midi_track_event_encoder_top_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d track bytes outstanding", track_bytes_due.size());
    $display("midi_track_event_encoder_top_tb failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mtee_pkg.sv
sv/mtee_ifs.sv
sv/mtee_front.sv
sv/mtee_queue.sv
sv/mtee_back.sv
sv/midi_track_event_encoder_top.sv
sv/mtee_checker.sv
tb/midi_track_event_encoder_top_tb.sv
